### rtl/core/smq_pkg.sv
// Shared types and constants of the stable max-priority queue.
package smq_pkg;

    localparam int DEPTH_DEFAULT          = 16;
    localparam int TAG_BITS_DEFAULT       = 16;
    localparam int PRIORITY_BITS_DEFAULT  = 16;
    localparam int CMD_FIFO_DEPTH         = 2;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_TAKE   = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } cmd_ctl_t;

endpackage

### rtl/core/smq_front.sv
// Front end: accepts input beats, decodes the command and queues it for the back end.
module smq_front #(
    parameter int TAG_BITS      = smq_pkg::TAG_BITS_DEFAULT,
    parameter int PRIORITY_BITS = smq_pkg::PRIORITY_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     in_cmd,
    input  logic [TAG_BITS-1:0]      in_tag,
    input  logic [PRIORITY_BITS-1:0] in_prio,
    output smq_pkg::cmd_ctl_t        cmd_ctl,
    output logic [TAG_BITS-1:0]      cmd_tag,
    output logic [PRIORITY_BITS-1:0] cmd_prio,
    input  logic                     cmd_pop
);

    localparam int EW = 1 + TAG_BITS + PRIORITY_BITS;
    localparam int PW = (smq_pkg::CMD_FIFO_DEPTH > 1) ? $clog2(smq_pkg::CMD_FIFO_DEPTH) : 1;
    localparam int FW = $clog2(smq_pkg::CMD_FIFO_DEPTH + 1);

    logic [EW-1:0] fifo_mem [smq_pkg::CMD_FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic          push;
    logic          pop;
    smq_pkg::op_t  in_op;
    logic [EW-1:0] head;

    assign in_op    = smq_pkg::op_t'(in_cmd);
    assign in_ready = (fill_reg != FW'(smq_pkg::CMD_FIFO_DEPTH));
    assign push     = in_valid && in_ready;
    assign pop      = cmd_pop && (fill_reg != '0);
    assign head     = fifo_mem[rd_ptr_reg];

    assign cmd_ctl.valid = (fill_reg != '0);
    assign cmd_ctl.op    = smq_pkg::op_t'(head[EW-1]);
    assign cmd_tag       = head[TAG_BITS-1:0];
    assign cmd_prio      = head[TAG_BITS+PRIORITY_BITS-1:TAG_BITS];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(smq_pkg::CMD_FIFO_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(smq_pkg::CMD_FIFO_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= {in_op, in_prio, in_tag};
        end
    end

endmodule

### rtl/core/smq_back.sv
// Back end: entry store, maximum scan, compaction and the result register.
module smq_back #(
    parameter int DEPTH         = smq_pkg::DEPTH_DEFAULT,
    parameter int TAG_BITS      = smq_pkg::TAG_BITS_DEFAULT,
    parameter int PRIORITY_BITS = smq_pkg::PRIORITY_BITS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  smq_pkg::cmd_ctl_t        cmd_ctl,
    input  logic [TAG_BITS-1:0]      cmd_tag,
    input  logic [PRIORITY_BITS-1:0] cmd_prio,
    output logic                     cmd_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output smq_pkg::status_t         out_status,
    output logic [TAG_BITS-1:0]      out_tag,
    output logic [PRIORITY_BITS-1:0] out_prio,
    output logic                     out_empty
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = TAG_BITS + PRIORITY_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } state_t;

    logic [EW-1:0]            mem [DEPTH];
    state_t                   state_reg;
    logic [CW-1:0]            cnt_reg;
    logic [CW-1:0]            addr_reg;
    logic                     rvld_reg;
    logic [IW-1:0]            ridx_reg;
    logic [EW-1:0]            rdata_reg;
    logic [IW-1:0]            best_idx_reg;
    logic [TAG_BITS-1:0]      best_tag_reg;
    logic [PRIORITY_BITS-1:0] best_prio_reg;
    logic                     out_valid_reg;
    smq_pkg::status_t         out_status_reg;
    logic [TAG_BITS-1:0]      out_tag_reg;
    logic [PRIORITY_BITS-1:0] out_prio_reg;
    logic                     out_empty_reg;

    logic                     full;
    logic                     issue;
    logic [CW-1:0]            cnt_m1;
    logic                     last_data;
    logic                     take_new;
    logic [IW-1:0]            best_idx_next;
    logic signed [PRIORITY_BITS-1:0] rd_prio;
    logic                     we;
    logic [IW-1:0]            wa;
    logic [EW-1:0]            wd;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign cnt_m1    = cnt_reg - CW'(1);
    assign issue     = (state_reg != S_IDLE) && (addr_reg < cnt_reg);
    assign rd_prio   = rdata_reg[EW-1:TAG_BITS];
    assign take_new  = (ridx_reg == '0) || (rd_prio > $signed(best_prio_reg));
    assign last_data = rvld_reg && (ridx_reg == cnt_m1[IW-1:0]);
    assign best_idx_next = take_new ? ridx_reg : best_idx_reg;
    assign cmd_pop   = (state_reg == S_IDLE) && cmd_ctl.valid && !out_valid_reg;

    always_comb
    begin
        we = 1'b0;
        wa = cnt_reg[IW-1:0];
        wd = {cmd_prio, cmd_tag};
        if (cmd_pop && (cmd_ctl.op == smq_pkg::OP_INSERT) && !full)
        begin
            we = 1'b1;
        end
        else if ((state_reg == S_SHIFT) && rvld_reg)
        begin
            we = 1'b1;
            wa = ridx_reg - IW'(1);
            wd = rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rdata_reg <= mem[addr_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            addr_reg       <= '0;
            rvld_reg       <= 1'b0;
            ridx_reg       <= '0;
            best_idx_reg   <= '0;
            best_tag_reg   <= '0;
            best_prio_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= smq_pkg::ST_INSERTED;
            out_tag_reg    <= '0;
            out_prio_reg   <= '0;
            out_empty_reg  <= 1'b0;
        end
        else
        begin
            rvld_reg <= issue;
            ridx_reg <= addr_reg[IW-1:0];
            if (issue)
            begin
                addr_reg <= addr_reg + CW'(1);
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_pop)
                    begin
                        out_tag_reg  <= '0;
                        out_prio_reg <= '0;
                        if (cmd_ctl.op == smq_pkg::OP_INSERT)
                        begin
                            out_valid_reg <= 1'b1;
                            out_empty_reg <= 1'b0;
                            if (full)
                            begin
                                out_status_reg <= smq_pkg::ST_FULL;
                            end
                            else
                            begin
                                out_status_reg <= smq_pkg::ST_INSERTED;
                                cnt_reg        <= cnt_reg + CW'(1);
                            end
                        end
                        else if (cnt_reg == '0)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_status_reg <= smq_pkg::ST_EMPTY;
                            out_empty_reg  <= 1'b1;
                        end
                        else
                        begin
                            addr_reg  <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (rvld_reg && take_new)
                    begin
                        best_idx_reg  <= ridx_reg;
                        best_tag_reg  <= rdata_reg[TAG_BITS-1:0];
                        best_prio_reg <= rdata_reg[EW-1:TAG_BITS];
                    end
                    if (last_data)
                    begin
                        addr_reg  <= CW'(best_idx_next) + CW'(1);
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    if (!issue && !rvld_reg)
                    begin
                        cnt_reg        <= cnt_m1;
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= smq_pkg::ST_SERVED;
                        out_tag_reg    <= best_tag_reg;
                        out_prio_reg   <= best_prio_reg;
                        out_empty_reg  <= (cnt_reg == CW'(1));
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_tag    = out_tag_reg;
    assign out_prio   = out_prio_reg;
    assign out_empty  = out_empty_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending while a take is in progress");

    a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (cnt_reg != '0))
        else $error("take in progress on an empty store");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (out_empty_reg == (cnt_reg == '0)))
        else $error("now_empty disagrees with the entry count");

endmodule

### rtl/core/stable_max_priority_queue.sv
// Top level of the stable max-priority queue: command front end and execution back end.
//
// Channel  Dir  tdata                                    tuser
// s_axis   in   client_tag, priority_req                 cmd
// m_axis   out  served_tag, served_priority, now_empty   status
//
// An insert, or a take on an empty queue, gives its result in the cycle after the back end
// takes it from the command queue. A take scans all held entries for the maximum, then
// moves each entry above the winner down one place before it gives its result. Reset clears
// the entry count, the command queue and the result register; the entry store is not cleared.
// A two-beat command queue keeps s_tready high for up to two beats while a result waits.
module stable_max_priority_queue #(
    parameter int DEPTH         = smq_pkg::DEPTH_DEFAULT,
    parameter int TAG_BITS      = smq_pkg::TAG_BITS_DEFAULT,
    parameter int PRIORITY_BITS = smq_pkg::PRIORITY_BITS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // client_tag, priority_req, zero padding
    input  logic [((TAG_BITS+PRIORITY_BITS+7)/8)*8-1:0]   s_tdata,
    // cmd
    input  logic [0:0]                                    s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // served_tag, served_priority, now_empty, zero padding
    output logic [((TAG_BITS+PRIORITY_BITS+8)/8)*8-1:0]   m_tdata,
    // status
    output logic [1:0]                                    m_tuser
);

    localparam int OW = ((TAG_BITS + PRIORITY_BITS + 8) / 8) * 8;

    smq_pkg::cmd_ctl_t        cmd_ctl;
    logic [TAG_BITS-1:0]      cmd_tag;
    logic [PRIORITY_BITS-1:0] cmd_prio;
    logic                     cmd_pop;
    smq_pkg::status_t         out_status;
    logic [TAG_BITS-1:0]      out_tag;
    logic [PRIORITY_BITS-1:0] out_prio;
    logic                     out_empty;

    smq_front #(
        .TAG_BITS      (TAG_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser[0]),
        .in_tag   (s_tdata[TAG_BITS-1:0]),
        .in_prio  (s_tdata[TAG_BITS+PRIORITY_BITS-1:TAG_BITS]),
        .cmd_ctl  (cmd_ctl),
        .cmd_tag  (cmd_tag),
        .cmd_prio (cmd_prio),
        .cmd_pop  (cmd_pop)
    );

    smq_back #(
        .DEPTH         (DEPTH),
        .TAG_BITS      (TAG_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_ctl    (cmd_ctl),
        .cmd_tag    (cmd_tag),
        .cmd_prio   (cmd_prio),
        .cmd_pop    (cmd_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_tag    (out_tag),
        .out_prio   (out_prio),
        .out_empty  (out_empty)
    );

    assign m_tdata = OW'({out_empty, out_prio, out_tag});
    assign m_tuser = out_status;

endmodule
